// ----- design/servo_ramp_pwm_top_defines.svh -----
// ----------------------------------------------------------------------------
// servo_ramp_pwm_top_defines.svh
// Assertion macros shared by the servo ramp PWM design. Both sample on clk_i
// and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERVO_RAMP_PWM_TOP_DEFINES_SVH
`define SERVO_RAMP_PWM_TOP_DEFINES_SVH

// Same-cycle implication
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Shared widths, register indexes, reset values and the command/status
// bundles between the servo ramp controller and datapath.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int SRP_PULSE_BITS = 16;

  localparam int TICK_W     = 16;
  localparam int STEP_W     = 8;
  localparam int HOLD_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIODS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIODS = 2'd3;

  // Reset values
  localparam logic [TICK_W-1:0] PERIOD_US_RST    = 16'd20000;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST   = 8'd20;
  localparam logic [STEP_W-1:0] STEP_PERIODS_RST = 8'd3;
  localparam logic [HOLD_W-1:0] HOLD_PERIODS_RST = 10'd50;

  // What the result beat reports as pulse width
  typedef enum logic [1:0] {
    OUT_IDLE,
    OUT_START,
    OUT_RUN
  } out_sel_e;

  typedef struct packed {
    logic     load;      // start command: load widths, start divide
    logic     run;       // active tick: advance in-period counter
    logic     pip_inc;   // count one more period in this phase
    logic     pip_clr;   // restart period count
    logic     seg_adv;   // step width by delta, clamped to goal
    logic     to_goal;   // snap width to goal at end of ramp
    logic     out_load;  // capture a result beat
    out_sel_e out_sel;
    logic     out_busy;
    logic     out_done;
  } cmd_t;

  typedef struct packed {
    logic period_end;    // this tick closes a PWM period
    logic seg_last;      // this period closes a ramp segment
    logic last_seg;      // all ramp increments are used up
    logic hold_last;     // this period closes the hold phase
    logic hold_zero;     // no hold phase configured
    logic div_done;      // delta is valid from next cycle
  } status_t;

endpackage

// ----- design/servo_ramp_pwm_top.sv -----
// ----------------------------------------------------------------------------
// servo_ramp_pwm_top
// Servo PWM generator with a linear pulse width ramp and a hold phase.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o| mode_i, start_pulse_i, target_pulse_i
//   out     | output    | out_valid_o/out_stall_i | pwm_out_o, pulse_now_o,
//           |           |                      | busy_res_o, move_done_o
//   cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// Ticks can be accepted every cycle while the divider is idle and the output does not stall.
// A start beat runs the serial delta divider, one quotient bit per cycle:
// input is stalled after the start beat is accepted until the divider is done.
// The result beat sits in an output register; a new beat is accepted in the
// same cycle the previous one is taken. Stall on the output holds the input.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "servo_ramp_pwm_top_defines.svh"

module servo_ramp_pwm_top
  import srp_pkg::*;
#(
  parameter int PULSE_BITS = SRP_PULSE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [PULSE_BITS-1:0] start_pulse_i,
  input  logic [PULSE_BITS-1:0] target_pulse_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  pwm_out_o,
  output logic [PULSE_BITS-1:0] pulse_now_o,
  output logic                  busy_res_o,
  output logic                  move_done_o
);

  cmd_t    cmd;
  status_t status;

  srp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srp_dp #(
    .PULSE_BITS (PULSE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_pulse_i  (start_pulse_i),
    .target_pulse_i (target_pulse_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .pwm_out_o      (pwm_out_o),
    .pulse_now_o    (pulse_now_o),
    .busy_res_o     (busy_res_o),
    .move_done_o    (move_done_o)
  );

  // A finished move is reported on a busy tick
  `SRP_ASSERT_IMP(a_done_busy, out_valid_o && move_done_o, busy_res_o,
                  "move_done without busy")
  // Idle beats carry a low line and zero width
  `SRP_ASSERT_IMP(a_idle_quiet, out_valid_o && !busy_res_o,
                  !pwm_out_o && (pulse_now_o == '0), "idle beat not quiet")
  // Input is held while the delta divider runs
  `SRP_ASSERT_NXT(a_div_stall, cmd.load, in_stall_o, "input taken during divide")

endmodule

// ----- design/srp_div.sv -----
// ----------------------------------------------------------------------------
// srp_div
// Unsigned restoring divider, one quotient bit per cycle. Divides a
// PULSE_BITS wide magnitude by an 8-bit nonzero divisor.
// ----------------------------------------------------------------------------
module srp_div
  import srp_pkg::*;
#(
  parameter int PULSE_BITS = SRP_PULSE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PULSE_BITS-1:0] dividend_i,
  input  logic [STEP_W-1:0]     divisor_i,
  output logic                  done_o,
  output logic [PULSE_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(PULSE_BITS + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]     dvs_q, dvs_d;
  logic [PULSE_BITS-1:0] qd_q, qd_d;
  logic [STEP_W:0]       trial;
  logic [STEP_W:0]       diff;
  logic                  qbit;

  // One restoring step: shift in the next dividend bit, try a subtract
  assign trial = {rem_q, qd_q[PULSE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qd_d   = qd_q;
    if (start_i) begin
      cnt_d  = PULSE_BITS[CNT_W-1:0];
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      qd_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = qbit ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      qd_d  = {qd_q[PULSE_BITS-2:0], qbit};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    qd_q  <= qd_d;
  end

  assign done_o = done_q;
  assign quot_o = qd_q;

endmodule

// ----- design/srp_dp.sv -----
// ----------------------------------------------------------------------------
// srp_dp
// Datapath of the servo ramp PWM: configuration registers, period and
// segment counters, pulse width with clamped ramp step, delta divider and
// the result beat register.
// ----------------------------------------------------------------------------
module srp_dp
  import srp_pkg::*;
#(
  parameter int PULSE_BITS = SRP_PULSE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PULSE_BITS-1:0] start_pulse_i,
  input  logic [PULSE_BITS-1:0] target_pulse_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  pwm_out_o,
  output logic [PULSE_BITS-1:0] pulse_now_o,
  output logic                  busy_res_o,
  output logic                  move_done_o
);

  localparam int CMP_W = ((PULSE_BITS > TICK_W) ? PULSE_BITS : TICK_W) + 1;

  // Configuration
  logic [TICK_W-1:0] period_q;
  logic [STEP_W-1:0] step_count_q;
  logic [STEP_W-1:0] step_periods_q;
  logic [HOLD_W-1:0] hold_q;

  // Move state
  logic [TICK_W-1:0]            tick_q;
  logic [PULSE_BITS-1:0]        cur_q;
  logic [PULSE_BITS-1:0]        goal_q;
  logic signed [PULSE_BITS:0]   delta_q;
  logic                         neg_q;
  logic [STEP_W-1:0]            seg_q;
  logic [HOLD_W-1:0]            pip_q;

  // Result beat
  logic                  pwm_q;
  logic [PULSE_BITS-1:0] pulse_q;
  logic                  busy_q;
  logic                  done_q;

  logic [PULSE_BITS:0]        diff;
  logic [PULSE_BITS:0]        diff_neg;
  logic [PULSE_BITS-1:0]      mag;
  logic [STEP_W-1:0]          divisor;
  logic                       div_done;
  logic [PULSE_BITS-1:0]      quot;
  logic signed [PULSE_BITS+1:0] step_sum;
  logic signed [PULSE_BITS+1:0] goal_ext;
  logic [PULSE_BITS-1:0]      width_next;
  logic                       pwm_level;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= PERIOD_US_RST;
      step_count_q   <= STEP_COUNT_RST;
      step_periods_q <= STEP_PERIODS_RST;
      hold_q         <= HOLD_PERIODS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_US:    period_q       <= cfg_data_i[TICK_W-1:0];
        REG_STEP_COUNT:   step_count_q   <= cfg_data_i[STEP_W-1:0];
        REG_STEP_PERIODS: step_periods_q <= cfg_data_i[STEP_W-1:0];
        REG_HOLD_PERIODS: hold_q         <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed span of the move, split into sign and magnitude for the divider
  assign diff     = {1'b0, target_pulse_i} - {1'b0, start_pulse_i};
  assign diff_neg = -diff;
  assign mag      = diff[PULSE_BITS] ? diff_neg[PULSE_BITS-1:0] : diff[PULSE_BITS-1:0];
  assign divisor  = (step_count_q == '0) ? STEP_W'(1) : step_count_q;

  srp_div #(
    .PULSE_BITS (PULSE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (mag),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Ramp step, clamped so it never passes the goal
  assign step_sum = $signed({2'b00, cur_q}) + $signed({delta_q[PULSE_BITS], delta_q});
  assign goal_ext = $signed({2'b00, goal_q});

  always_comb begin
    width_next = step_sum[PULSE_BITS-1:0];
    if (!delta_q[PULSE_BITS] && (delta_q != '0) && (step_sum > goal_ext)) begin
      width_next = goal_q;
    end else if (delta_q[PULSE_BITS] && (step_sum < goal_ext)) begin
      width_next = goal_q;
    end
  end

  // Move state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      cur_q   <= '0;
      goal_q  <= '0;
      delta_q <= '0;
      neg_q   <= 1'b0;
      seg_q   <= '0;
      pip_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        tick_q <= '0;
        cur_q  <= start_pulse_i;
        goal_q <= target_pulse_i;
        neg_q  <= diff[PULSE_BITS];
        seg_q  <= '0;
        pip_q  <= '0;
      end else begin
        if (cmd_i.run) begin
          tick_q <= status_o.period_end ? '0 : tick_q + TICK_W'(1);
        end
        if (cmd_i.pip_clr) begin
          pip_q <= '0;
        end else if (cmd_i.pip_inc) begin
          pip_q <= pip_q + HOLD_W'(1);
        end
        if (cmd_i.seg_adv) begin
          seg_q <= seg_q + STEP_W'(1);
          cur_q <= width_next;
        end else if (cmd_i.to_goal) begin
          cur_q <= goal_q;
        end
      end
      if (div_done) begin
        delta_q <= neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      end
    end
  end

  // Status to the controller
  assign status_o.period_end = ({1'b0, tick_q} + (TICK_W+1)'(1)) >= {1'b0, period_q};
  assign status_o.seg_last   = ({1'b0, pip_q} + (HOLD_W+1)'(1))
                               >= (HOLD_W+1)'(step_periods_q);
  assign status_o.last_seg   = (seg_q >= step_count_q);
  assign status_o.hold_last  = ({1'b0, pip_q} + (HOLD_W+1)'(1)) >= {1'b0, hold_q};
  assign status_o.hold_zero  = (hold_q == '0);
  assign status_o.div_done   = div_done;

  // Line is high while the in-period tick is below the width
  assign pwm_level = (CMP_W'(tick_q) < CMP_W'(cur_q));

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      busy_q <= cmd_i.out_busy;
      done_q <= cmd_i.out_done;
      case (cmd_i.out_sel)
        OUT_START: begin
          pwm_q   <= 1'b0;
          pulse_q <= start_pulse_i;
        end
        OUT_RUN: begin
          pwm_q   <= pwm_level;
          pulse_q <= cur_q;
        end
        default: begin
          pwm_q   <= 1'b0;
          pulse_q <= '0;
        end
      endcase
    end
  end

  assign pwm_out_o   = pwm_q;
  assign pulse_now_o = pulse_q;
  assign busy_res_o  = busy_q;
  assign move_done_o = done_q;

endmodule

// ----- design/srp_ctrl.sv -----
// ----------------------------------------------------------------------------
// srp_ctrl
// Controller of the servo ramp PWM: move phase state machine, input and
// output handshakes, and the per-beat commands to the datapath.
// ----------------------------------------------------------------------------
module srp_ctrl
  import srp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    mode_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RAMP = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // Hold input while delta is computed or while the result beat is stuck
  assign in_stall_o = (state_q == ST_DIV) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;

    if ((state_q == ST_DIV) && status_i.div_done) begin
      state_d = ST_RAMP;
    end

    if (accept) begin
      cmd_o.out_load = 1'b1;
      if (mode_i) begin
        // Start command: restarts any move
        cmd_o.load     = 1'b1;
        cmd_o.out_sel  = OUT_START;
        cmd_o.out_busy = 1'b1;
        state_d        = ST_DIV;
      end else begin
        case (state_q)
          ST_RAMP: begin
            cmd_o.run      = 1'b1;
            cmd_o.out_sel  = OUT_RUN;
            cmd_o.out_busy = 1'b1;
            if (status_i.period_end) begin
              if (status_i.seg_last) begin
                cmd_o.pip_clr = 1'b1;
                if (status_i.last_seg) begin
                  // End of ramp: sit on the goal, then hold or finish
                  cmd_o.to_goal = 1'b1;
                  if (status_i.hold_zero) begin
                    cmd_o.out_done = 1'b1;
                    state_d        = ST_IDLE;
                  end else begin
                    state_d = ST_HOLD;
                  end
                end else begin
                  cmd_o.seg_adv = 1'b1;
                end
              end else begin
                cmd_o.pip_inc = 1'b1;
              end
            end
          end
          ST_HOLD: begin
            cmd_o.run      = 1'b1;
            cmd_o.out_sel  = OUT_RUN;
            cmd_o.out_busy = 1'b1;
            if (status_i.period_end) begin
              if (status_i.hold_last) begin
                cmd_o.pip_clr  = 1'b1;
                cmd_o.out_done = 1'b1;
                state_d        = ST_IDLE;
              end else begin
                cmd_o.pip_inc = 1'b1;
              end
            end
          end
          default: begin
            cmd_o.out_sel = OUT_IDLE;
          end
        endcase
      end
    end
  end

  // Output beat register valid
  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
